[rtl/core/lpfr_pkg.sv]
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

    // Frame capacity in bytes (16..255)
    localparam logic [7:0]  BUFFER_BYTES = 8'd128;
    localparam logic [7:0]  SYNC_BYTE    = 8'hAA;
    // Header + check bytes on top of the payload
    localparam logic [16:0] FRAME_EXTRA  = 17'd10;

    // Header byte positions
    localparam logic [7:0]  IDX_TYPE_LO  = 8'd2;
    localparam logic [7:0]  IDX_TYPE_HI  = 8'd3;
    localparam logic [7:0]  IDX_LEN_LO   = 8'd4;
    localparam logic [7:0]  IDX_LEN_HI   = 8'd5;

    typedef struct packed {
        logic [7:0]  count;        // bytes held in current frame, 0 = hunting
        logic [15:0] length_word;
        logic [15:0] type_word;
    } lpfr_state_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic        in_frame;
        logic        frame_end;
        logic        frame_drop;
        logic [15:0] content_type;
        logic [15:0] payload_length;
    } lpfr_result_t;

endpackage

[rtl/core/lpfr_step.sv]
// ----------------------------------------------------------------------------
// lpfr_step
// Per-beat parser: next frame state and result for one received byte.
// ----------------------------------------------------------------------------
module lpfr_step (
    input  lpfr_pkg::lpfr_state_t  cur,
    input  logic [7:0]             rx_byte,
    output lpfr_pkg::lpfr_state_t  nxt,
    output lpfr_pkg::lpfr_result_t res
);
    import lpfr_pkg::*;

    logic [16:0] pos_plus_one;
    logic [16:0] frame_total;
    logic        keep;
    logic        drop;
    logic        fend;

    always_comb
    begin
        nxt          = cur;
        keep         = 1'b1;
        drop         = 1'b0;
        fend         = 1'b0;
        pos_plus_one = {9'd0, cur.count} + 17'd1;
        frame_total  = {1'b0, cur.length_word} + FRAME_EXTRA;

        if (cur.count == 8'd0)
        begin
            if (rx_byte != SYNC_BYTE)
            begin
                keep = 1'b0;
            end
            else
            begin
                nxt.type_word   = 16'd0;
                nxt.length_word = 16'd0;
                nxt.count       = 8'd1;
            end
        end
        else if (cur.count >= BUFFER_BYTES)
        begin
            // overflow: abandon frame, hunt from next byte
            drop      = 1'b1;
            nxt.count = 8'd0;
        end
        else
        begin
            case (cur.count)
                IDX_TYPE_LO: nxt.type_word[7:0]    = rx_byte;
                IDX_TYPE_HI: nxt.type_word[15:8]   = rx_byte;
                IDX_LEN_LO:  nxt.length_word[7:0]  = rx_byte;
                IDX_LEN_HI:  nxt.length_word[15:8] = rx_byte;
                default:     ;
            endcase
            frame_total = {1'b0, nxt.length_word} + FRAME_EXTRA;
            // 17-bit compare so a huge length never wraps into an early end
            if (cur.count >= IDX_LEN_HI && pos_plus_one == frame_total)
            begin
                fend      = 1'b1;
                nxt.count = 8'd0;
            end
            else
            begin
                nxt.count = pos_plus_one[7:0];
            end
        end

        res.data_byte      = rx_byte;
        res.byte_index     = keep ? cur.count : 8'd0;
        res.in_frame       = keep;
        res.frame_end      = fend;
        res.frame_drop     = drop;
        res.content_type   = keep ? nxt.type_word : 16'd0;
        res.payload_length = keep ? nxt.length_word : 16'd0;
    end

endmodule

[rtl/core/length_prefixed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Sync-byte / length-field deframer: tags each received byte with its frame
// position, content type and length, and flags frame end and overflow drop.
// ----------------------------------------------------------------------------
// The result beat of an accepted byte is registered before it reaches the output.
// Throughput: one byte per cycle unless a held beat is stalled by the sink; the
//   frame state and the result register are both updated in the accepting cycle.
// Reset (rst_n low, async): hunting for sync, length and type words zero,
//   output register empty.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    // received byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic        in_frame,
    output logic        frame_end,
    output logic        frame_drop,
    output logic [15:0] content_type,
    output logic [15:0] payload_length
);
    import lpfr_pkg::*;

    // Frame state: position counter plus the header words captured so far
    lpfr_state_t  state_reg;
    lpfr_state_t  state_next;
    // Output register holding one result beat
    lpfr_result_t res_reg;
    lpfr_result_t res_next;
    logic         out_valid_reg;
    logic         in_take;

    // Stall only while a result beat is held and the sink is stalling; the
    // register is refilled in the same cycle the old beat leaves.
    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    lpfr_step u_step (
        .cur     (state_reg),
        .rx_byte (rx_byte),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_byte      = res_reg.data_byte;
    assign byte_index     = res_reg.byte_index;
    assign in_frame       = res_reg.in_frame;
    assign frame_end      = res_reg.frame_end;
    assign frame_drop     = res_reg.frame_drop;
    assign content_type   = res_reg.content_type;
    assign payload_length = res_reg.payload_length;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Position counter never runs past capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count <= BUFFER_BYTES)
        else $error("frame counter beyond capacity");

    // A non-sync byte while hunting keeps the receiver hunting
    a_hunt_stays: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && state_reg.count == 8'd0 && rx_byte != SYNC_BYTE
        |=> state_reg.count == 8'd0)
        else $error("hunt left without sync byte");

    // End and drop are exclusive and only occur inside a frame
    a_end_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (frame_end || frame_drop)
        |-> in_frame && !(frame_end && frame_drop))
        else $error("bad end/drop flags");

    // Every frame end or drop returns the parser to hunting
    a_close_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (res_next.frame_end || res_next.frame_drop)
        |=> state_reg.count == 8'd0)
        else $error("frame close did not resume hunting");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: length_prefixed_frame_receiver regression
// Streams noise, well-formed frames, oversized and broken frames through the
// deframer. A clocked driver feeds bytes from a queue, and a model of the
// frame tracker tags each accepted byte. A clocked monitor checks every
// result beat against the oldest tag. Idle and stall rates change by phase.
// ----------------------------------------------------------------------------
module tb;
    import lpfr_pkg::*;

    // watchdog: cycles with no beat on either channel before giving up
    localparam int QUIET_LIMIT = 4000;
    localparam int BYTES_PER_PHASE = 485;
    localparam int NUM_PHASES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        in_frame;
    logic        frame_end;
    logic        frame_drop;
    logic [15:0] content_type;
    logic [15:0] payload_length;

    length_prefixed_frame_receiver DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .in_frame       (in_frame),
        .frame_end      (frame_end),
        .frame_drop     (frame_drop),
        .content_type   (content_type),
        .payload_length (payload_length)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bytes waiting to go out, and the tags predicted for bytes already taken
    logic [7:0]   rx_bytes[$];
    lpfr_result_t pending_tags[$];

    // Idle / stall rates in percent, changed per phase
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;

    int errors = 0;
    int n_sent = 0;
    int n_seen = 0;
    int n_ends = 0;
    int n_drops = 0;
    int n_hunt = 0;
    int quiet = 0;

    // Frame tracker state mirrored from the block
    logic [7:0]  trk_count = 8'd0;   // 0 = hunting for sync
    logic [15:0] trk_len = 16'd0;
    logic [15:0] trk_type = 16'd0;

    // Tags one byte the way the deframer should, and advances the tracker.
    function automatic lpfr_result_t deframe_byte(input logic [7:0] b);
        lpfr_result_t tag;
        logic [7:0]   idx;
        tag = '0;
        tag.data_byte = b;
        idx = trk_count;
        if (idx == 8'd0) begin
            // hunting: anything but sync is passed out with all tags zero
            if (b != SYNC_BYTE)
                return tag;
            trk_type = 16'd0;
            trk_len = 16'd0;
            trk_count = 8'd1;
        end else if (idx >= BUFFER_BYTES) begin
            // overflow byte is never taken as a sync; words hold till next sync
            tag.frame_drop = 1'b1;
            trk_count = 8'd0;
        end else begin
            case (idx)
                IDX_TYPE_LO: trk_type[7:0] = b;
                IDX_TYPE_HI: trk_type[15:8] = b;
                IDX_LEN_LO:  trk_len[7:0] = b;
                IDX_LEN_HI:  trk_len[15:8] = b;
                default: ;
            endcase
            // 17-bit compare so a huge length cannot wrap into an early end
            if (idx >= IDX_LEN_HI
                && ({9'd0, idx} + 17'd1) == ({1'b0, trk_len} + FRAME_EXTRA))
            begin
                tag.frame_end = 1'b1;
                trk_count = 8'd0;
            end else begin
                trk_count = idx + 8'd1;
            end
        end
        tag.byte_index = idx;
        tag.in_frame = 1'b1;
        tag.content_type = trk_type;
        tag.payload_length = trk_len;
        return tag;
    endfunction

    // Driver: a beat once raised stays put until taken; a new one is loaded
    // only when the slot is free and the idle draw allows it.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic slot_free;
        if (!rst_n) begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
        end else begin
            slot_free = !in_valid || !in_stall;
            if (in_valid && !in_stall) begin
                pending_tags.push_back(deframe_byte(rx_byte));
                n_sent++;
            end
            if (slot_free) begin
                if (rx_bytes.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest tag, then draws
    // the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        lpfr_result_t got;
        lpfr_result_t want;
        logic bad;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got.data_byte = data_byte;
                got.byte_index = byte_index;
                got.in_frame = in_frame;
                got.frame_end = frame_end;
                got.frame_drop = frame_drop;
                got.content_type = content_type;
                got.payload_length = payload_length;
                n_seen++;
                if (frame_end === 1'b1)
                    n_ends++;
                if (frame_drop === 1'b1)
                    n_drops++;
                if (in_frame === 1'b0)
                    n_hunt++;
                if (pending_tags.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result beat %0d with nothing expected: %s %02h idx %0d",
                                 n_seen, "byte", data_byte, byte_index);
                end else begin
                    want = pending_tags.pop_front();
                    bad = (got.data_byte !== want.data_byte)
                        || (got.byte_index !== want.byte_index)
                        || (got.in_frame !== want.in_frame)
                        || (got.frame_end !== want.frame_end)
                        || (got.frame_drop !== want.frame_drop)
                        || (got.content_type !== want.content_type)
                        || (got.payload_length !== want.payload_length);
                    if (bad) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"ERROR: beat %0d exp byte %02h idx %0d fr %b",
                                      " end %b drop %b type %04h len %04h"},
                                     n_seen, want.data_byte, want.byte_index, want.in_frame,
                                     want.frame_end, want.frame_drop, want.content_type,
                                     want.payload_length);
                            $display({"       beat %0d got byte %02h idx %0d fr %b",
                                      " end %b drop %b type %04h len %04h"},
                                     n_seen, got.data_byte, got.byte_index, got.in_frame,
                                     got.frame_end, got.frame_drop, got.content_type,
                                     got.payload_length);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d tags outstanding",
                         quiet, pending_tags.size());
                $display("length_prefixed_frame_receiver regression: fail");
                $finish;
            end
        end
    end

    // Header, payload and check bytes of one frame. An oversized frame is
    // cut at the byte that overflows the buffer.
    task automatic push_frame(input logic [15:0] ctype, input logic [15:0] plen,
                              input bit sync_fill);
        int body;
        rx_bytes.push_back(SYNC_BYTE);
        rx_bytes.push_back(8'($urandom_range(0, 255)));
        rx_bytes.push_back(ctype[7:0]);
        rx_bytes.push_back(ctype[15:8]);
        rx_bytes.push_back(plen[7:0]);
        rx_bytes.push_back(plen[15:8]);
        if (int'(plen) + 10 <= int'(BUFFER_BYTES))
            body = int'(plen) + 4;
        else
            body = int'(BUFFER_BYTES) - 5;  // indices 6 up to the overflow byte
        for (int i = 0; i < body; i++)
            rx_bytes.push_back(sync_fill ? SYNC_BYTE : 8'($urandom_range(0, 255)));
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++)
            rx_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Returns once every queued byte went out and every tag was matched
    task automatic wait_idle();
        while (rx_bytes.size() != 0 || in_valid || pending_tags.size() != 0)
            @(negedge clk);
    endtask

    int unsigned tx_pcts[NUM_PHASES] = '{0, 74, 0, 7};
    int unsigned rx_pcts[NUM_PHASES] = '{0, 0, 74, 7};

    initial
    begin : stimulus
        int start;
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: hunting extremes, then the smallest frames
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(8'hFF);
        rx_bytes.push_back(8'h55);
        push_frame(16'h0000, 16'd0, 1'b0);
        push_frame(16'hFFFF, 16'd1, 1'b1);   // sync value inside payload
        // sender holds off until the block has answered everything
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            tx_idle_pct = tx_pcts[p];
            rx_stall_pct = rx_pcts[p];
            start = n_sent + rx_bytes.size();
            if (p == 0) begin
                // capacity edges: fills the buffer exactly, one over, huge length
                push_frame(16'($urandom_range(0, 65535)), 16'(int'(BUFFER_BYTES) - 10), 1'b0);
                push_frame(16'hFFFF, 16'(int'(BUFFER_BYTES) - 9), 1'b0);
                push_frame(16'h0000, 16'hFFFF, 1'b0);
            end
            while (n_sent + rx_bytes.size() - start < BYTES_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    push_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 30)), 1'b0);
                else if (pick < 70)
                    push_frame(16'($urandom_range(0, 65535)),
                               16'($urandom_range(31, int'(BUFFER_BYTES) - 10)), 1'b0);
                else if (pick < 73)
                    push_frame(16'($urandom_range(0, 65535)), 16'(int'(BUFFER_BYTES) - 10), 1'b0);
                else if (pick < 76)
                    push_frame(16'($urandom_range(0, 65535)), 16'(int'(BUFFER_BYTES) - 9), 1'b0);
                else if (pick < 78)
                    push_frame(16'($urandom_range(0, 65535)),
                               16'($urandom_range(32768, 65535)), 1'b0);
                else if (pick < 88)
                    push_noise($urandom_range(1, 5));
                else if (pick < 95) begin
                    // broken header: sync then junk, may swallow later frames
                    rx_bytes.push_back(SYNC_BYTE);
                    push_noise($urandom_range(1, 12));
                end else
                    push_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 20)), 1'b1);
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (pending_tags.size() != 0) begin
            errors += pending_tags.size();
            $display("ERROR: %0d expected results never arrived", pending_tags.size());
        end
        $display("covered %0d bytes over %0d idle/stall phases: %0d frames ended, %0d dropped",
                 n_sent, NUM_PHASES, n_ends, n_drops);
        $display("%0d bytes discarded while hunting, %0d mismatches", n_hunt, errors);
        if (errors == 0)
            $display("length_prefixed_frame_receiver regression: pass");
        else
            $display("length_prefixed_frame_receiver regression: fail");
        $finish;
    end

endmodule
